FILE: hdl/wpcm_pkg.sv
// Package for the sliding-window peak counter: widths, limits, register map
// and the control struct shared by the flag chain and its cells.
// No dependencies.
package wpcm_pkg;

	// sizing
	localparam int WINDOW_MAX   = 256;
	localparam int SEQUENCE_MAX = 65536;
	localparam int WIN_MIN      = 3;

	// field widths
	localparam int HEIGHT_W = 32;
	localparam int WLEN_W   = 9;
	localparam int PARTS_W  = 8;
	localparam int START_W  = 17;

	// internal widths
	localparam int IDX_W      = $clog2(SEQUENCE_MAX) + 1;
	localparam int BEST_IDX_W = $clog2(SEQUENCE_MAX);
	localparam int CNT_W      = $clog2(SEQUENCE_MAX);

	// flag chain: cell j holds the flag of the position j+1 behind the newest
	localparam int LINE_LEN = WINDOW_MAX - WIN_MIN;
	localparam int TAP_W    = $clog2(LINE_LEN);

	// configuration port
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 2;
	localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(WIN_MIN);
	localparam logic [PARTS_W-1:0] PARTS_MAX = '1;

	// register indexes
	localparam int REG_WINDOW_LENGTH = 0;

	// shift and clear for every cell of the flag chain
	typedef struct packed {
		logic shift;
		logic clear;
	} line_ctrl_t;

endpackage

FILE: hdl/wpcm_in_if.sv
// Sample channel: valid/ready handshake carrying one height item.
// Depends on wpcm_pkg.
interface wpcm_in_if
	import wpcm_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [HEIGHT_W-1:0] height;
	logic                last_sample;

	modport source (output valid, output height, output last_sample, input ready);
	modport sink (input valid, input height, input last_sample, output ready);
endinterface

FILE: hdl/wpcm_out_if.sv
// Result channel: valid/ready handshake carrying one best-window item.
// Depends on wpcm_pkg.
interface wpcm_out_if
	import wpcm_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [PARTS_W-1:0] best_parts;
	logic [START_W-1:0] best_start;

	modport source (output valid, output best_parts, output best_start, input ready);
	modport sink (input valid, input best_parts, input best_start, output ready);
endinterface

FILE: hdl/wpcm_cell.sv
// One cell of the peak-flag chain: holds one flag, passes it on each shift
// and reports it when its place matches the selected tap. Depends on wpcm_pkg.
module wpcm_cell
	import wpcm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  line_ctrl_t       ctrl,
	input  logic [TAP_W-1:0] cell_idx,
	input  logic [TAP_W-1:0] tap_idx,
	input  logic             d,
	output logic             q,
	output logic             tap_hit
);

	logic flag_q;

	// clear on sequence end, otherwise take the neighbour's flag on a shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (ctrl.clear) begin
			flag_q <= 1'b0;
		end else if (ctrl.shift) begin
			flag_q <= d;
		end
	end

	assign q       = flag_q;
	assign tap_hit = flag_q & (cell_idx == tap_idx);

endmodule

FILE: hdl/wpcm_flag_line.sv
// Chain of flag cells: the newest peak flag enters at cell 0 and moves one
// cell per sample; one cell chosen by the window length is read out.
// Depends on wpcm_pkg and wpcm_cell.
module wpcm_flag_line
	import wpcm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  line_ctrl_t       ctrl,
	input  logic             flag_in,
	input  logic [TAP_W-1:0] tap_idx,
	output logic             tap
);

	logic [LINE_LEN-1:0] chain;
	logic [LINE_LEN-1:0] hits;

	// build the row of cells, each fed by its younger neighbour
	for (genvar j = 0; j < LINE_LEN; j++) begin : g_cell
		logic cell_d;
		if (j == 0) begin : g_head
			assign cell_d = flag_in;
		end else begin : g_body
			assign cell_d = chain[j-1];
		end
		wpcm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.cell_idx (TAP_W'(j)),
			.tap_idx  (tap_idx),
			.d        (cell_d),
			.q        (chain[j]),
			.tap_hit  (hits[j])
		);
	end

	// at most one cell matches the tap
	assign tap = |hits;

endmodule

FILE: hdl/window_peak_count_max.sv
// Sliding-window peak counter with arg-max. Takes one height sample per clock
// with no stall of its own; a result item appears in the cycle after the sample
// marked last, from an output register, so a waiting result only holds off
// the input while the result side also stalls. The per-sample work is one
// pass through the neighbour compares, the running count and the best-window
// compare; peak flags travel down a chain of 253 one-bit cells, one cell per
// sample, and the cell chosen by window_length gives the flag leaving the
// window. A last sample emits the result and clears all state in the same
// cycle, so the next sequence may start on the following clock.
module window_peak_count_max
	import wpcm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	wpcm_in_if.sink               samples,
	wpcm_out_if.source            results,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam logic [WLEN_W-1:0] WIN_LO = WLEN_W'(WIN_MIN);
	localparam logic [WLEN_W-1:0] WIN_HI = WLEN_W'(WINDOW_MAX);
	localparam logic [WLEN_W-1:0] TAP_OFS = WLEN_W'(WIN_MIN + 1);

	logic [WLEN_W-1:0]     wlen_q;
	logic [HEIGHT_W-1:0]   prior_q;
	logic [HEIGHT_W-1:0]   older_q;
	logic [IDX_W-1:0]      idx_q;
	logic [CNT_W-1:0]      run_q;
	logic [CNT_W-1:0]      best_q;
	logic [BEST_IDX_W-1:0] best_idx_q;
	logic                  res_valid_q;
	logic [PARTS_W-1:0]    parts_q;
	logic [START_W-1:0]    start_q;

	logic                  take;
	logic                  active;
	logic [WLEN_W-1:0]     k_eff;
	logic [WLEN_W-1:0]     tap_full;
	logic                  flag;
	logic                  judge;
	logic                  leaving;
	logic                  line_tap;
	logic [CNT_W-1:0]      cnt_inc;
	logic [CNT_W-1:0]      run_d;
	logic [CNT_W-1:0]      best_d;
	logic [BEST_IDX_W-1:0] best_idx_d;
	logic [BEST_IDX_W-1:0] start;
	logic [CNT_W:0]        parts_wide;
	logic                  cfg_wr;
	line_ctrl_t            line_ctrl;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = APB_DATA_W'(wlen_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= WLEN_RESET;
		end else if (cfg_wr && (paddr == APB_ADDR_W'(REG_WINDOW_LENGTH * 4))) begin
			wlen_q <= pwdata[WLEN_W-1:0];
		end
	end

	// clamp the window length into its working range
	always_comb begin
		if (wlen_q < WIN_LO) begin
			k_eff = WIN_LO;
		end else if (wlen_q > WIN_HI) begin
			k_eff = WIN_HI;
		end else begin
			k_eff = wlen_q;
		end
	end

	// handshake: a held result stalls input only while the result side stalls
	assign samples.ready = !res_valid_q || results.ready;
	assign take          = samples.valid && samples.ready;
	assign active        = idx_q < IDX_W'(SEQUENCE_MAX);

	// the previous sample is now known to be a peak or not
	assign flag = (idx_q >= IDX_W'(2)) && (prior_q > older_q) && (prior_q > samples.height);

	// flag chain
	assign line_ctrl.shift = take && active && (idx_q >= IDX_W'(2));
	assign line_ctrl.clear = take && samples.last_sample;
	assign tap_full        = k_eff - TAP_OFS;

	wpcm_flag_line u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (line_ctrl),
		.flag_in (flag),
		.tap_idx (tap_full[TAP_W-1:0]),
		.tap     (line_tap)
	);

	// count, judge the window that ends here, drop the leaving flag
	always_comb begin
		cnt_inc    = run_q + CNT_W'(flag);
		judge      = (idx_q + IDX_W'(1)) >= IDX_W'(k_eff);
		start      = BEST_IDX_W'(idx_q + IDX_W'(1) - IDX_W'(k_eff));
		leaving    = (k_eff == WIN_LO) ? flag : line_tap;
		best_d     = best_q;
		best_idx_d = best_idx_q;
		run_d      = cnt_inc;
		if (active) begin
			if (judge) begin
				if (cnt_inc > best_q) begin
					best_d     = cnt_inc;
					best_idx_d = start;
				end
				if (leaving && (cnt_inc != '0)) begin
					run_d = cnt_inc - CNT_W'(1);
				end
			end
		end else begin
			run_d = run_q;
		end
		parts_wide = {1'b0, best_d} + (CNT_W+1)'(1);
	end

	// sequence state: advance on each sample, clear after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_q    <= '0;
			older_q    <= '0;
			idx_q      <= '0;
			run_q      <= '0;
			best_q     <= '0;
			best_idx_q <= '0;
		end else if (take) begin
			if (samples.last_sample) begin
				prior_q    <= '0;
				older_q    <= '0;
				idx_q      <= '0;
				run_q      <= '0;
				best_q     <= '0;
				best_idx_q <= '0;
			end else if (active) begin
				older_q    <= prior_q;
				prior_q    <= samples.height;
				idx_q      <= idx_q + IDX_W'(1);
				run_q      <= run_d;
				best_q     <= best_d;
				best_idx_q <= best_idx_d;
			end
		end
	end

	// result register: load on the last sample, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && samples.last_sample) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && samples.last_sample) begin
			parts_q <= (parts_wide > (CNT_W+1)'(PARTS_MAX)) ? PARTS_MAX
				: parts_wide[PARTS_W-1:0];
			start_q <= START_W'({1'b0, best_idx_d} + (BEST_IDX_W+1)'(1));
		end
	end

	assign results.valid      = res_valid_q;
	assign results.best_parts = parts_q;
	assign results.best_start = start_q;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for window_peak_count_max: random height sequences, window
// settings over the APB port, result items checked against an in-bench predictor.
// Depends on wpcm_pkg, wpcm_in_if, wpcm_out_if and the block itself.
module tb;
	import wpcm_pkg::*;

	localparam int RAND_ITEMS   = 1750;
	localparam int RAND_RESULTS = 40;
	// slowest run: ~2k items plus sender gaps and result stalls, taken ~4x over
	localparam int CYCLE_LIMIT  = 200_000;
	localparam logic [APB_ADDR_W-1:0] WLEN_ADDR = APB_ADDR_W'(REG_WINDOW_LENGTH * 4);

	typedef struct packed {
		logic [HEIGHT_W-1:0] height;
		logic                last_sample;
	} sample_t;

	typedef struct packed {
		logic [PARTS_W-1:0] best_parts;
		logic [START_W-1:0] best_start;
	} window_result_t;

	typedef enum int {HT_TINY, HT_FULL, HT_EDGE, HT_ZIGZAG} height_style_e;

	logic clk = 1'b0;
	logic arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	wpcm_in_if  sample_ch ();
	wpcm_out_if result_ch ();

	window_peak_count_max u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (sample_ch),
		.results (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	sample_t        sample_q[$];
	window_result_t best_window_q[$];
	int unsigned    items_queued;
	int unsigned    samples_taken;
	int unsigned    fail_count;
	int unsigned    cycle_count;
	int unsigned    rand_items;
	int unsigned    rand_results;

	// predictor state
	logic [WLEN_W-1:0]     win_reg;
	logic [HEIGHT_W-1:0]   h_prev;
	logic [HEIGHT_W-1:0]   h_prev2;
	logic [IDX_W-1:0]      seq_pos;
	logic [WINDOW_MAX-1:0] peak_ring;
	logic [CNT_W-1:0]      inside_peaks;
	logic [CNT_W-1:0]      top_count;
	logic [BEST_IDX_W-1:0] top_start;

	function automatic void clear_sequence();
		h_prev       = '0;
		h_prev2      = '0;
		seq_pos      = '0;
		peak_ring    = '0;
		inside_peaks = '0;
		top_count    = '0;
		top_start    = '0;
	endfunction

	// clamp the register to the supported window range
	function automatic int unsigned eff_window(input logic [WLEN_W-1:0] w);
		if (w < WIN_MIN)
			return WIN_MIN;
		if (w > WINDOW_MAX)
			return WINDOW_MAX;
		return w;
	endfunction

	// advance the peak counter by one accepted sample; queue a result on the last one
	function automatic void track_peaks(input logic [HEIGHT_W-1:0] h, input logic last_mark);
		int unsigned    pos;
		int unsigned    k;
		int unsigned    first;
		int unsigned    parts;
		logic           is_peak;
		window_result_t outcome;
		if (seq_pos < SEQUENCE_MAX) begin
			pos = seq_pos;
			k   = eff_window(win_reg);
			// the previous sample is now settled as a peak or not
			if (pos >= 2) begin
				is_peak = (h_prev > h_prev2) && (h_prev > h);
				peak_ring[(pos - 1) % WINDOW_MAX] = is_peak;
				inside_peaks = inside_peaks + is_peak;
			end
			// judge the window ending here, then drop its first inner flag
			if (pos + 1 >= k) begin
				first = pos + 1 - k;
				if (inside_peaks > top_count) begin
					top_count = inside_peaks;
					top_start = BEST_IDX_W'(first);
				end
				if (peak_ring[(first + 1) % WINDOW_MAX] && inside_peaks != 0)
					inside_peaks = inside_peaks - 1'b1;
			end
			h_prev2 = h_prev;
			h_prev  = h;
			seq_pos = seq_pos + 1'b1;
		end
		if (last_mark) begin
			parts = top_count + 1;
			if (parts > PARTS_MAX)
				parts = PARTS_MAX;
			outcome.best_parts = PARTS_W'(parts);
			outcome.best_start = START_W'(top_start) + 1'b1;
			best_window_q.push_back(outcome);
			clear_sequence();
		end
	endfunction

	// sender: bursts of random length, random gaps between them
	int unsigned gap_left;
	int unsigned burst_left;
	sample_t     drive_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ch.valid       <= 1'b0;
			sample_ch.height      <= '0;
			sample_ch.last_sample <= 1'b0;
			gap_left   = 0;
			burst_left = 0;
		end else begin
			if (sample_ch.valid && sample_ch.ready) begin
				track_peaks(sample_ch.height, sample_ch.last_sample);
				samples_taken++;
			end
			if (!sample_ch.valid || sample_ch.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					sample_ch.valid <= 1'b0;
				end else if (sample_q.size() == 0) begin
					sample_ch.valid <= 1'b0;
				end else begin
					drive_item = sample_q.pop_front();
					sample_ch.valid       <= 1'b1;
					sample_ch.height      <= drive_item.height;
					sample_ch.last_sample <= drive_item.last_sample;
					if (burst_left != 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 31);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	// receiver: calm stretches, otherwise random stalls of its own
	int unsigned stall_left;
	int unsigned calm_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_left = 0;
			calm_left  = 0;
		end else if (stall_left != 0) begin
			stall_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
			if (calm_left != 0)
				calm_left--;
			else if ($urandom_range(0, 99) < 4)
				calm_left = $urandom_range(50, 400);
			else if ($urandom_range(0, 2) == 0)
				stall_left = $urandom_range(1, 12);
		end
	end

	// compare each result item against the oldest expectation
	window_result_t want;

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (best_window_q.size() == 0) begin
				$display("%0t: result with none expected: best_parts %0d best_start %0d",
					$time, result_ch.best_parts, result_ch.best_start);
				fail_count++;
			end else begin
				want = best_window_q.pop_front();
				if (result_ch.best_parts !== want.best_parts) begin
					$display("%0t: best_parts expected %0d got %0d",
						$time, want.best_parts, result_ch.best_parts);
					fail_count++;
				end
				if (result_ch.best_start !== want.best_start) begin
					$display("%0t: best_start expected %0d got %0d",
						$time, want.best_start, result_ch.best_start);
					fail_count++;
				end
			end
		end
	end

	// hard stop
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: cycle limit reached", $time);
			$display("** window_peak_count_max: FAILED **");
			$finish;
		end
	end

	task automatic push_sample(input logic [HEIGHT_W-1:0] h, input logic last_mark);
		sample_q.push_back('{height: h, last_sample: last_mark});
		items_queued++;
	endtask

	// hold until every item is taken and every result is back, then let the block settle
	task automatic wait_drained();
		while (samples_taken != items_queued || best_window_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write the window register, then read it back
	task automatic write_window(input logic [WLEN_W-1:0] value);
		logic [APB_DATA_W-1:0] readback;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= WLEN_ADDR;
		pwdata  <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		win_reg = value;
		// go straight into the setup of the read
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		readback = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (readback !== APB_DATA_W'(value)) begin
			$display("%0t: window_length readback expected %0d got %0d",
				$time, value, readback);
			fail_count++;
		end
	endtask

	function automatic logic [WLEN_W-1:0] pick_window();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return WLEN_W'($urandom_range(0, 12));
			6, 7:             return WLEN_W'($urandom_range(13, 80));
			8: begin
				case ($urandom_range(0, 3))
					0:       return WLEN_W'(255);
					1:       return WLEN_W'(256);
					2:       return WLEN_W'(257);
					default: return '1;
				endcase
			end
			default:          return WLEN_W'($urandom_range(0, 511));
		endcase
	endfunction

	function automatic logic [HEIGHT_W-1:0] pick_height(input height_style_e style,
		input int unsigned pos);
		case (style)
			HT_TINY: return $urandom_range(0, 3);
			HT_FULL: return $urandom;
			HT_EDGE: begin
				case ($urandom_range(0, 4))
					0:       return '0;
					1:       return '1;
					2:       return {{(HEIGHT_W-1){1'b1}}, 1'b0};
					3:       return HEIGHT_W'(1);
					default: return $urandom;
				endcase
			end
			default: begin
				// alternate low and high, now and then break the pattern
				if ($urandom_range(0, 9) == 0)
					return $urandom_range(0, 3000);
				return pos[0] ? $urandom_range(1001, 32'hFFFF_FFFF) : $urandom_range(0, 1000);
			end
		endcase
	endfunction

	// one random sequence; leave it open when close is low
	task automatic send_random_seq(input logic close);
		int unsigned   keff;
		int unsigned   len;
		height_style_e style;
		keff = eff_window(win_reg);
		case ($urandom_range(0, 7))
			0:       len = $urandom_range(1, keff - 1);
			1:       len = keff;
			default: len = $urandom_range(keff + 1, keff + keff / 2 + 30);
		endcase
		style = height_style_e'($urandom_range(0, 3));
		for (int unsigned i = 0; i < len; i++)
			push_sample(pick_height(style, i), close && (i == len - 1));
		rand_items += len;
		if (close)
			rand_results++;
	endtask

	initial begin
		int unsigned n_seq;
		sample_ch.valid       = 1'b0;
		sample_ch.height      = '0;
		sample_ch.last_sample = 1'b0;
		result_ch.ready       = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		arst_n  = 1'b0;
		win_reg = WLEN_RESET;
		clear_sequence();
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset window of three: single sample and two samples are too short
		push_sample('1, 1'b1);
		push_sample('0, 1'b0); push_sample('1, 1'b1);
		// plateau is not a peak; two peaks, earliest window kept
		push_sample('0, 1'b0); push_sample('1, 1'b0); push_sample('0, 1'b0);
		push_sample(7, 1'b0);  push_sample(7, 1'b0);  push_sample(0, 1'b0);
		push_sample(9, 1'b0);  push_sample(1, 1'b1);
		// flat run fills a window but finds nothing
		push_sample(5, 1'b0); push_sample(5, 1'b0); push_sample(5, 1'b1);
		wait_drained();

		// below the minimum acts as three; equal later windows do not replace
		write_window('0);
		push_sample(1, 1'b0); push_sample(3, 1'b0); push_sample(1, 1'b0);
		push_sample(3, 1'b0); push_sample(1, 1'b1);
		wait_drained();

		// above the maximum acts as the maximum
		write_window('1);
		push_sample(0, 1'b0); push_sample(8, 1'b0); push_sample(0, 1'b1);
		wait_drained();

		// window changed in the middle of a sequence
		write_window(WLEN_W'(4));
		push_sample(0, 1'b0); push_sample(9, 1'b0); push_sample(0, 1'b0);
		push_sample(9, 1'b0); push_sample(0, 1'b0);
		wait_drained();
		write_window(WLEN_W'(6));
		push_sample(9, 1'b0); push_sample(0, 1'b0); push_sample(2, 1'b1);
		wait_drained();

		// random phases, each under its own window setting
		rand_items   = 0;
		rand_results = 0;
		while (rand_items < RAND_ITEMS || rand_results < RAND_RESULTS) begin
			write_window(pick_window());
			n_seq = (eff_window(win_reg) > 64) ? 1 : $urandom_range(2, 6);
			repeat (n_seq) begin
				send_random_seq(1'b1);
				if ($urandom_range(0, 7) == 0)
					wait_drained();
			end
			// now and then carry an open sequence over the next write
			if ($urandom_range(0, 2) == 0)
				send_random_seq(1'b0);
			wait_drained();
		end
		// close whatever is still open
		push_sample($urandom, 1'b1);
		wait_drained();
		repeat (10) @(posedge clk);

		if (fail_count == 0)
			$display("** window_peak_count_max: PASSED **");
		else
			$display("** window_peak_count_max: FAILED **");
		$finish;
	end

endmodule
